// ===== rtl/evr_pkg.sv =====
package evr_pkg;

    localparam int VW           = 34;
    localparam int TRIG_BITS    = 30;
    localparam int ATAN_ENTRIES = 30;

    localparam logic signed [VW-1:0] CORDIC_GAIN = 34'sd652032875;

    typedef logic signed [VW-1:0] comp_t;

    typedef struct packed {
        logic  skip;
        comp_t c;
        comp_t s;
    } trig_t;

    typedef struct packed {
        comp_t [2:0]       v;
        logic  [2:0][31:0] p;
    } vp_t;

    typedef struct packed {
        comp_t [2:0]       v;
        logic  [2:0][31:0] p;
        trig_t [2:0]       t;
    } vec_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        sat;
    } res_t;

    function automatic comp_t atan_turn(input int unsigned i);
        comp_t r;
        case (i)
            0:       r = 34'sd536870912;
            1:       r = 34'sd316933406;
            2:       r = 34'sd167458907;
            3:       r = 34'sd85004756;
            4:       r = 34'sd42667331;
            5:       r = 34'sd21354465;
            6:       r = 34'sd10679838;
            7:       r = 34'sd5340245;
            8:       r = 34'sd2670163;
            9:       r = 34'sd1335087;
            10:      r = 34'sd667544;
            11:      r = 34'sd333772;
            12:      r = 34'sd166886;
            13:      r = 34'sd83443;
            14:      r = 34'sd41722;
            15:      r = 34'sd20861;
            16:      r = 34'sd10430;
            17:      r = 34'sd5215;
            18:      r = 34'sd2608;
            19:      r = 34'sd1304;
            20:      r = 34'sd652;
            21:      r = 34'sd326;
            22:      r = 34'sd163;
            23:      r = 34'sd81;
            24:      r = 34'sd41;
            25:      r = 34'sd20;
            26:      r = 34'sd10;
            27:      r = 34'sd5;
            28:      r = 34'sd3;
            29:      r = 34'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/evr_turn_conv.sv =====
module evr_turn_conv
    import evr_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] angle,
    output logic [31:0] turn,
    output logic        zero
);

    localparam int SHIFT = 32 - FRAC_BITS;

    // floor(u / 45) = (u * (2^32 + RECIP_LO)) >> 38 for every 32-bit u
    localparam logic [30:0] RECIP_LO = 31'd1813430637;
    localparam logic [31:0] Q_BIAS   = 32'd47721858;
    localparam logic [5:0]  R_BIAS   = 6'd38;

    logic [31:0] tbl [45];

    for (genvar r = 0; r < 45; r++)
    begin : g_tbl
        localparam longint TV = ((longint'(r) <<< SHIFT) + 180) / 360;
        assign tbl[r] = 32'(TV);
    end

    logic [31:0] u1_reg;
    logic        zero1_reg;
    logic [62:0] prod_reg;
    logic [31:0] u2_reg;
    logic        zero2_reg;
    logic [26:0] qu_reg;
    logic [5:0]  u3_reg;
    logic        zero3_reg;
    logic [31:0] q_reg;
    logic [5:0]  rr_reg;
    logic        zero4_reg;
    logic [31:0] turn_reg;
    logic        zero5_reg;

    logic [64:0] full_prod;
    logic [11:0] qm;
    logic [5:0]  ru;
    logic [31:0] q_next;
    logic [5:0]  rr_next;
    logic [31:0] turn_next;

    always_comb
    begin
        full_prod = {1'b0, u2_reg, 32'd0} + {2'b00, prod_reg};
        qm        = 12'(qu_reg[5:0]) * 12'd45;
        ru        = u3_reg - qm[5:0];
        if (ru < R_BIAS)
        begin
            q_next  = 32'(qu_reg) - Q_BIAS - 32'd1;
            rr_next = ru + 6'd7;
        end
        else
        begin
            q_next  = 32'(qu_reg) - Q_BIAS;
            rr_next = ru - R_BIAS;
        end
        turn_next = (q_reg << (SHIFT - 3)) + tbl[rr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u1_reg    <= angle ^ 32'h8000_0000;
            zero1_reg <= (angle == 32'd0);
            prod_reg  <= 63'(u1_reg) * 63'(RECIP_LO);
            u2_reg    <= u1_reg;
            zero2_reg <= zero1_reg;
            qu_reg    <= full_prod[64:38];
            u3_reg    <= u2_reg[5:0];
            zero3_reg <= zero2_reg;
            q_reg     <= q_next;
            rr_reg    <= rr_next;
            zero4_reg <= zero3_reg;
            turn_reg  <= turn_next;
            zero5_reg <= zero4_reg;
        end
    end

    assign turn = turn_reg;
    assign zero = zero5_reg;

endmodule

// ===== rtl/evr_cordic.sv =====
module evr_cordic
    import evr_pkg::*;
#(
    parameter int CORDIC_STEPS = 24
)
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] turn,
    input  logic        zero,
    output trig_t       trig
);

    localparam int N = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    comp_t x_reg    [N+1];
    comp_t y_reg    [N+1];
    comp_t z_reg    [N+1];
    logic  flip_reg [N+1];
    logic  zero_reg [N+1];
    trig_t trig_reg;

    logic [31:0] turn_rot;
    logic        flip;
    logic [31:0] zb;

    assign turn_rot = turn + 32'h4000_0000;
    assign flip     = turn_rot[31];
    assign zb       = flip ? (turn ^ 32'h8000_0000) : turn;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= {{(VW-32){zb[31]}}, zb};
            flip_reg[0] <= flip;
            zero_reg[0] <= zero;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        localparam comp_t ATAN = atan_turn(i);

        comp_t dx;
        comp_t dy;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][VW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - ATAN;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + ATAN;
                end
                flip_reg[i+1] <= flip_reg[i];
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trig_reg.skip <= zero_reg[N];
            trig_reg.c    <= flip_reg[N] ? -x_reg[N] : x_reg[N];
            trig_reg.s    <= flip_reg[N] ? -y_reg[N] : y_reg[N];
        end
    end

    assign trig = trig_reg;

endmodule

// ===== rtl/evr_rotate.sv =====
module evr_rotate
    import evr_pkg::*;
#(
    parameter int AXIS = 0
)
(
    input  logic clk,
    input  logic en,
    input  vec_t vin,
    output vec_t vout
);

    localparam int A_IDX = (AXIS == 0) ? 1 : ((AXIS == 1) ? 2 : 0);
    localparam int B_IDX = (AXIS == 0) ? 2 : ((AXIS == 1) ? 0 : 1);

    vec_t        vec1_reg;
    logic [63:0] pac_reg;
    logic [63:0] pbs_reg;
    logic [63:0] pbc_reg;
    logic [63:0] pas_reg;
    vec_t        vec2_reg;

    logic signed [2*VW-1:0] prod_ac;
    logic signed [2*VW-1:0] prod_bs;
    logic signed [2*VW-1:0] prod_bc;
    logic signed [2*VW-1:0] prod_as;

    assign prod_ac = $signed(vin.v[A_IDX]) * $signed(vin.t[AXIS].c);
    assign prod_bs = $signed(vin.v[B_IDX]) * $signed(vin.t[AXIS].s);
    assign prod_bc = $signed(vin.v[B_IDX]) * $signed(vin.t[AXIS].c);
    assign prod_as = $signed(vin.v[A_IDX]) * $signed(vin.t[AXIS].s);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec1_reg <= vin;
            pac_reg  <= prod_ac[63:0];
            pbs_reg  <= prod_bs[63:0];
            pbc_reg  <= prod_bc[63:0];
            pas_reg  <= prod_as[63:0];
        end
    end

    logic [63:0]        sum_a;
    logic [63:0]        sum_b;
    logic signed [63:0] shr_a;
    logic signed [63:0] shr_b;
    vec_t               vec_next;

    always_comb
    begin
        sum_a = pac_reg - pbs_reg + 64'h2000_0000;
        sum_b = pbc_reg + pas_reg + 64'h2000_0000;
        shr_a = $signed(sum_a) >>> TRIG_BITS;
        shr_b = $signed(sum_b) >>> TRIG_BITS;
        vec_next = vec1_reg;
        if (!vec1_reg.t[AXIS].skip)
        begin
            vec_next.v[A_IDX] = shr_a[VW-1:0];
            vec_next.v[B_IDX] = shr_b[VW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec2_reg <= vec_next;
        end
    end

    assign vout = vec2_reg;

endmodule

// ===== rtl/evr_out_buf.sv =====
module evr_out_buf
    import evr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    output logic en,
    output logic out_valid,
    input  logic out_ready,
    output res_t head
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    res_t       buf0_reg;
    res_t       buf0_next;
    res_t       buf1_reg;
    res_t       buf1_next;
    logic       pop;

    assign en        = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign head      = buf0_reg;

    always_comb
    begin
        count_next = count_reg;
        buf0_next  = buf0_reg;
        buf1_next  = buf1_reg;
        unique case (count_reg)
            2'd0:
            begin
                if (push)
                begin
                    buf0_next  = push_data;
                    count_next = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                begin
                    buf0_next = push_data;
                end
                else if (push)
                begin
                    buf1_next  = push_data;
                    count_next = 2'd2;
                end
                else if (pop)
                begin
                    count_next = 2'd0;
                end
            end
            2'd2:
            begin
                if (pop)
                begin
                    buf0_next  = buf1_reg;
                    count_next = 2'd1;
                end
            end
            default:
            begin
                count_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf0_reg <= buf0_next;
        buf1_reg <= buf1_next;
    end

endmodule

// ===== rtl/euler_vector_rotate_unit.sv =====
// Rotates a Q16.16 3-vector by Euler angles in degrees, about x, then y, then z,
// either about the origin (op 0) or about a pivot point (op 1). One transaction
// enters per cycle while in_ready is high, and results leave in order. Each
// transaction passes in turn through these stages: five stages reduce each
// angle to binary turn units by reciprocal multiplication, one stage per CORDIC
// iteration plus two produce sine and cosine, each axis rotation takes two
// stages, then one clip stage and the output buffer; the three angles run in
// parallel lanes. A two-entry output buffer keeps the input open while one
// finished result waits; with two waiting, in_ready drops and the whole
// pipeline holds.
module euler_vector_rotate_unit
    import evr_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 24
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic signed [31:0] angle_x,
    input  logic signed [31:0] angle_y,
    input  logic signed [31:0] angle_z,
    input  logic signed [31:0] pivot_x,
    input  logic signed [31:0] pivot_y,
    input  logic signed [31:0] pivot_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] result_x,
    output logic signed [31:0] result_y,
    output logic signed [31:0] result_z,
    output logic               saturated
);

    localparam int CSTEPS   = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int TURN_LAT = 5;
    localparam int COR_LAT  = CSTEPS + 2;
    localparam int L1       = TURN_LAT + COR_LAT;
    localparam int NST      = L1 + 7;

    logic en;

    logic valid_reg [NST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    assign in_ready = en;

    logic [2:0][31:0] angles;
    logic [2:0][31:0] points;
    logic [2:0][31:0] pivots;
    trig_t [2:0]      trig;

    assign angles = {angle_z, angle_y, angle_x};
    assign points = {point_z, point_y, point_x};
    assign pivots = {pivot_z, pivot_y, pivot_x};

    for (genvar a = 0; a < 3; a++)
    begin : g_lane
        logic [31:0] turn;
        logic        zero;

        evr_turn_conv #(
            .FRAC_BITS (FRAC_BITS)
        ) u_turn (
            .clk   (clk),
            .en    (en),
            .angle (angles[a]),
            .turn  (turn),
            .zero  (zero)
        );

        evr_cordic #(
            .CORDIC_STEPS (CORDIC_STEPS)
        ) u_cordic (
            .clk  (clk),
            .en   (en),
            .turn (turn),
            .zero (zero),
            .trig (trig[a])
        );
    end

    vp_t vp_reg [L1];
    vp_t vp_in;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            vp_in.p[k] = op ? pivots[k] : 32'd0;
            vp_in.v[k] = {{(VW-32){points[k][31]}}, points[k]}
                       - {{(VW-32){vp_in.p[k][31]}}, vp_in.p[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vp_reg[0] <= vp_in;
            for (int k = 1; k < L1; k++)
            begin
                vp_reg[k] <= vp_reg[k-1];
            end
        end
    end

    vec_t rot_in;
    vec_t rot_x;
    vec_t rot_y;
    vec_t rot_z;

    always_comb
    begin
        rot_in.v = vp_reg[L1-1].v;
        rot_in.p = vp_reg[L1-1].p;
        rot_in.t = trig;
    end

    evr_rotate #(.AXIS(0)) u_rot_x (.clk(clk), .en(en), .vin(rot_in), .vout(rot_x));
    evr_rotate #(.AXIS(1)) u_rot_y (.clk(clk), .en(en), .vin(rot_x),  .vout(rot_y));
    evr_rotate #(.AXIS(2)) u_rot_z (.clk(clk), .en(en), .vin(rot_y),  .vout(rot_z));

    logic signed [VW:0]     sum    [3];
    logic        [2:0][31:0] clip;
    logic        [2:0]      clip_hit;
    res_t                   res_next;
    res_t                   res_reg;
    res_t                   head;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum[k] = {rot_z.v[k][VW-1], rot_z.v[k]}
                   + {{(VW+1-32){rot_z.p[k][31]}}, rot_z.p[k]};
            if (sum[k] > $signed(35'sd2147483647))
            begin
                clip[k]     = 32'h7FFF_FFFF;
                clip_hit[k] = 1'b1;
            end
            else if (sum[k] < -$signed(35'sd2147483648))
            begin
                clip[k]     = 32'h8000_0000;
                clip_hit[k] = 1'b1;
            end
            else
            begin
                clip[k]     = sum[k][31:0];
                clip_hit[k] = 1'b0;
            end
        end
        res_next.x   = clip[0];
        res_next.y   = clip[1];
        res_next.z   = clip[2];
        res_next.sat = |clip_hit;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    evr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (en && valid_reg[NST-1]),
        .push_data (res_reg),
        .en        (en),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign result_x  = head.x;
    assign result_y  = head.y;
    assign result_z  = head.z;
    assign saturated = head.sat;

endmodule

// ===== rtl/evr_checker.sv =====
module evr_assert
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        op,
    input logic [31:0] point_x,
    input logic [31:0] point_y,
    input logic [31:0] point_z,
    input logic [31:0] angle_x,
    input logic [31:0] angle_y,
    input logic [31:0] angle_z,
    input logic [31:0] pivot_x,
    input logic [31:0] pivot_y,
    input logic [31:0] pivot_z,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] result_x,
    input logic [31:0] result_y,
    input logic [31:0] result_z,
    input logic        saturated
);

    // hold the input closed only while results are queued
    a_full_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result waiting");

    a_full_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_ready && !(out_valid && out_ready)) |=> !in_ready)
        else $error("full buffer opened without a pop");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(result_x)
            && $stable(result_y) && $stable(result_z) && $stable(saturated)))
        else $error("stalled result changed");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
            (result_x == 32'h7FFF_FFFF || result_x == 32'h8000_0000
          || result_y == 32'h7FFF_FFFF || result_y == 32'h8000_0000
          || result_z == 32'h7FFF_FFFF || result_z == 32'h8000_0000))
        else $error("saturated flag without a clipped component");

endmodule

bind euler_vector_rotate_unit evr_assert u_evr_assert (.*);

// ===== sim/evr_checker.sv =====
module evr_checker
    import evr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               op,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic signed [31:0] angle_x,
    input  logic signed [31:0] angle_y,
    input  logic signed [31:0] angle_z,
    input  logic signed [31:0] pivot_x,
    input  logic signed [31:0] pivot_y,
    input  logic signed [31:0] pivot_z,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] result_x,
    input  logic signed [31:0] result_y,
    input  logic signed [31:0] result_z,
    input  logic               saturated,
    output int                 errors,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC   = 16;
    localparam int STEPS  = 24;
    localparam longint GAIN = 64'sd652032875;

    res_t rotated_q[$];

    function automatic longint arc_step(input int i);
        longint tbl[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
            163, 81, 41, 20, 10, 5, 3, 1};
        return tbl[i];
    endfunction

    function automatic logic [31:0] deg_to_turn(input longint deg);
        longint full;
        longint r;
        logic [63:0] t;
        full = 64'sd360 <<< FRAC;
        r = deg % full;
        if (r < 0)
            r += full;
        t = (64'(r) << (32 - FRAC)) + 64'd180;
        return 32'(t / 64'd360);
    endfunction

    function automatic void sin_cos(input logic [31:0] b, output longint c,
                                    output longint s);
        logic [31:0] sum;
        logic        flip;
        longint      z;
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        sum = b + 32'h4000_0000;
        flip = sum[31];
        z = longint'($signed(flip ? (b ^ 32'h8000_0000) : b));
        x = GAIN;
        y = 0;
        for (int i = 0; i < STEPS && i < 30; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= arc_step(i);
            end
            else
            begin
                x += dx; y -= dy; z += arc_step(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint round_trig(input longint sum);
        return (sum + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic [31:0] clip(input longint v, inout logic sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            v = 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            v = -64'sd2147483648;
        end
        return v[31:0];
    endfunction

    function automatic res_t rotate_vertex(input logic o, input logic [2:0][31:0] pt,
                                           input logic [2:0][31:0] ang,
                                           input logic [2:0][31:0] pv);
        longint v[3];
        longint p[3];
        longint c;
        longint s;
        longint na;
        longint nb;
        int     a;
        int     b;
        logic   sat;
        res_t   r;
        sat = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            v[k] = longint'($signed(pt[k]));
            p[k] = o ? longint'($signed(pv[k])) : 0;
            v[k] -= p[k];
        end
        for (int k = 0; k < 3; k++)
        begin
            if (ang[k] != 0)
            begin
                a = (k == 0) ? 1 : (k == 1) ? 2 : 0;
                b = (k == 0) ? 2 : (k == 1) ? 0 : 1;
                sin_cos(deg_to_turn(longint'($signed(ang[k]))), c, s);
                na = round_trig(v[a] * c - v[b] * s);
                nb = round_trig(v[b] * c + v[a] * s);
                v[a] = na;
                v[b] = nb;
            end
        end
        r.x = clip(v[0] + p[0], sat);
        r.y = clip(v[1] + p[1], sat);
        r.z = clip(v[2] + p[2], sat);
        r.sat = sat;
        return r;
    endfunction

    initial errors = 0;
    assign pending = rotated_q.size();

    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && in_valid && in_ready)
            rotated_q.push_back(rotate_vertex(op, {point_z, point_y, point_x},
                {angle_z, angle_y, angle_x}, {pivot_z, pivot_y, pivot_x}));
        if (rst_n && out_valid && out_ready)
        begin
            if (rotated_q.size() == 0)
            begin
                $error("result with no transaction pending");
                errors++;
            end
            else
            begin
                e = rotated_q.pop_front();
                if (result_x !== e.x)
                begin
                    $error("result_x exp %h got %h", e.x, result_x);
                    errors++;
                end
                if (result_y !== e.y)
                begin
                    $error("result_y exp %h got %h", e.y, result_y);
                    errors++;
                end
                if (result_z !== e.z)
                begin
                    $error("result_z exp %h got %h", e.z, result_z);
                    errors++;
                end
                if (saturated !== e.sat)
                begin
                    $error("saturated exp %b got %b", e.sat, saturated);
                    errors++;
                end
            end
        end
    end
endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic op;
    logic signed [31:0] point_x, point_y, point_z;
    logic signed [31:0] angle_x, angle_y, angle_z;
    logic signed [31:0] pivot_x, pivot_y, pivot_z;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] result_x, result_y, result_z;
    logic saturated;
    int errors;
    int pending;
    int cycles;
    bit stim_done;

    euler_vector_rotate_unit dut (.*);
    evr_checker chk (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 4000)) - 2000) <<< 16;
            3: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_angle();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'($signed($urandom_range(0, 8)) * 90) <<< 16;
            2: return 32'd360 <<< 16;
            3: return 32'h7FFF_FFFF;
            4: return 32'h8000_0000;
            5: return 32'($signed($urandom_range(0, 720)) - 360) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic send(input logic o, input logic [31:0] px, py, pz,
                        input logic [31:0] ax, ay, az, input logic [31:0] qx, qy, qz);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        op <= o;
        point_x <= px; point_y <= py; point_z <= pz;
        angle_x <= ax; angle_y <= ay; angle_z <= az;
        pivot_x <= qx; pivot_y <= qy; pivot_z <= qz;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // stall the output side in bursts
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_ready <= 1'b1;
            repeat ($urandom_range(0, 1) ? $urandom_range(1, 40) : 1) @(negedge clk);
            out_ready <= 1'b0;
            repeat (gap_len()) @(negedge clk);
        end
    end

    initial
    begin
        logic [31:0] dirs[6];
        stim_done = 0;
        rst_n = 0;
        in_valid = 0;
        op = 0;
        {point_x, point_y, point_z, angle_x, angle_y, angle_z} = '0;
        {pivot_x, pivot_y, pivot_z} = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        dirs = '{32'h0, 32'd90 <<< 16, 32'd180 <<< 16, 32'd270 <<< 16,
                 32'd360 <<< 16, -(32'd90 <<< 16)};
        foreach (dirs[i])
            send(i[0], 32'h1_0000, 32'h2_0000, 32'h3_0000, dirs[i], dirs[(i + 1) % 6],
                 dirs[(i + 2) % 6], 32'h5_0000, 32'hFFFF_0000, 32'h0);
        send(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd45 <<< 16,
             32'd45 <<< 16, 32'd45 <<< 16, 0, 0, 0);
        send(1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'd30 <<< 16,
             32'd135 <<< 16, 32'd200 <<< 16, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send(0, 32'hFFFF_FFFF, 32'h1, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1,
             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1234_5678,
             32'h8765_4321, 32'hFFFF_FFFF);
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
        for (int n = 0; n < 1000; n++)
        begin
            send($urandom_range(0, 1), pick_value(), pick_value(), pick_value(),
                 pick_angle(), pick_angle(), pick_angle(),
                 pick_value(), pick_value(), pick_value());
            if (n == 500)
            begin
                in_valid <= 1'b0;
                wait (pending == 0);
                @(negedge clk);
            end
        end
        in_valid <= 1'b0;
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        wait (pending == 0);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/evr_pkg.sv
rtl/evr_turn_conv.sv
rtl/evr_cordic.sv
rtl/evr_rotate.sv
rtl/evr_out_buf.sv
rtl/euler_vector_rotate_unit.sv
rtl/evr_checker.sv
sim/evr_checker.sv
sim/tb.sv
